// ----- design/rds_text_assembler_macros.svh -----
// assertion macros for the rds text assembler rtl
`ifndef RDS_TEXT_ASSEMBLER_MACROS_SVH
`define RDS_TEXT_ASSEMBLER_MACROS_SVH

// same-cycle implication under the active-low reset
`define RTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the active-low reset
`define RTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rta_pkg.sv -----
// shared types and constants of the rds text assembler
package rta_pkg;

  localparam int NAME_LEN    = 8;
  localparam int TEXT_LEN    = 64;
  localparam int CHAR_W      = 7;
  localparam int CHUNK_CHARS = 8;
  localparam int CHUNK_W     = CHAR_W * CHUNK_CHARS;
  localparam int TEXT_CHUNKS = TEXT_LEN / CHUNK_CHARS;
  localparam int NUM_CHUNKS  = TEXT_CHUNKS + 1;
  localparam int RT_SEG_CHARS = 4;
  localparam int PS_SEG_CHARS = 2;
  localparam int TEXT_MIN_LONG = 60;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [CHUNK_W-1:0] chunk_t;
  typedef logic [3:0]         chunk_idx_t;
  typedef logic [16:0]        freq_t;

  localparam freq_t      FREQ_RESET   = 17'd87500;
  localparam chunk_idx_t FIRST_CHUNK  = 4'd0;
  localparam chunk_idx_t LAST_CHUNK   = 4'(NUM_CHUNKS - 1);

  // group type codes in block b bits 15..12, version in bit 11
  localparam logic [3:0] GRP_TYPE_PS = 4'd0;
  localparam logic [3:0] GRP_TYPE_RT = 4'd2;
  localparam logic       GRP_VER_A   = 1'b0;
  localparam logic [3:0] TEXT_END_SEG = 4'd15;

  localparam char_t CHAR_CR    = 7'h0d;
  localparam char_t CHAR_LF    = 7'h0a;
  localparam char_t CHAR_SPACE = 7'h20;

  typedef enum logic {
    DONE_NAME = 1'b0,
    DONE_TEXT = 1'b1
  } done_kind_e;

  // per-group control handed to the staging units
  typedef struct packed {
    logic fire;
    logic wipe;
    logic is_ps;
    logic is_rt;
  } grp_ctl_t;

  typedef struct packed {
    logic       launch;
    done_kind_e kind;
  } emit_ctl_t;

  typedef struct packed {
    logic busy;
    logic free;
  } emit_st_t;

endpackage

// ----- design/rta_if.sv -----
// handshake channels for rds groups and published chunks

interface rta_group_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_a;
  logic [15:0] block_b;
  logic [15:0] block_c;
  logic [15:0] block_d;
  logic        clear_first;

  modport source (output valid, output block_a, output block_b, output block_c,
                  output block_d, output clear_first, input ready);
  modport sink   (input valid, input block_a, input block_b, input block_c,
                  input block_d, input clear_first, output ready);
endinterface

interface rta_chunk_if;
  logic        valid;
  logic        ready;
  logic [15:0] prog_id;
  logic [4:0]  prog_type;
  logic        done_kind;
  logic [3:0]  chunk_index;
  logic [55:0] chunk_chars;
  logic [16:0] freq_khz;
  logic        last;

  modport source (output valid, output prog_id, output prog_type, output done_kind,
                  output chunk_index, output chunk_chars, output freq_khz,
                  output last, input ready);
  modport sink   (input valid, input prog_id, input prog_type, input done_kind,
                  input chunk_index, input chunk_chars, input freq_khz,
                  input last, output ready);
endinterface

// ----- design/rta_name_unit.sv -----
// service name staging, completion check and published name
module rta_name_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rta_pkg::grp_ctl_t ctl_i,
  input  logic [1:0]       seg_i,
  input  rta_pkg::char_t   d_hi_i,
  input  rta_pkg::char_t   d_lo_i,
  output logic             done_o,
  output rta_pkg::chunk_t  name_chunk_o
);
  import rta_pkg::*;

  char_t stage_q [NAME_LEN];
  char_t stage_d [NAME_LEN];
  char_t pub_q   [NAME_LEN];
  char_t pub_d   [NAME_LEN];
  char_t upd     [NAME_LEN];
  logic [NAME_LEN-1:0] nz;

  always_comb begin
    for (int i = 0; i < NAME_LEN; i++) begin
      upd[i] = ctl_i.wipe ? '0 : stage_q[i];
      if (ctl_i.is_ps && (seg_i == 2'(i / PS_SEG_CHARS))) begin
        upd[i] = ((i % PS_SEG_CHARS) == 0) ? d_hi_i : d_lo_i;
      end
      nz[i] = |upd[i];
    end
  end

  assign done_o = ctl_i.fire && ctl_i.is_ps && (&nz);

  always_comb begin
    for (int i = 0; i < NAME_LEN; i++) begin
      stage_d[i] = stage_q[i];
      pub_d[i]   = pub_q[i];
      if (ctl_i.fire) begin
        stage_d[i] = done_o ? '0 : upd[i];
        if (done_o) begin
          pub_d[i] = upd[i];
        end else if (ctl_i.wipe) begin
          pub_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAME_LEN; i++) begin
        stage_q[i] <= '0;
        pub_q[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < NAME_LEN; i++) begin
        stage_q[i] <= stage_d[i];
        pub_q[i]   <= pub_d[i];
      end
    end
  end

  // first char in the high bits
  for (genvar j = 0; j < NAME_LEN; j++) begin : g_pack
    assign name_chunk_o[CHUNK_W-1-j*CHAR_W -: CHAR_W] = pub_q[j];
  end

endmodule

// ----- design/rta_text_unit.sv -----
// radiotext staging, end detection and published text
module rta_text_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rta_pkg::grp_ctl_t ctl_i,
  input  logic [3:0]       seg_i,
  input  logic             ab_i,
  input  rta_pkg::char_t   c_hi_i,
  input  rta_pkg::char_t   c_lo_i,
  input  rta_pkg::char_t   d_hi_i,
  input  rta_pkg::char_t   d_lo_i,
  output logic             done_o,
  output rta_pkg::chunk_t  text_chunks_o [rta_pkg::TEXT_CHUNKS]
);
  import rta_pkg::*;

  char_t stage_q [TEXT_LEN];
  char_t stage_d [TEXT_LEN];
  char_t pub_q   [TEXT_LEN];
  char_t pub_d   [TEXT_LEN];
  char_t upd     [TEXT_LEN];
  char_t seg_chars [RT_SEG_CHARS];
  logic  ab_q, ab_d;
  logic  wipe_stage;
  logic [TEXT_LEN-1:0] nz, blank, crlf;
  logic [TEXT_LEN:0]   pre;     // chars below this place are all nonzero
  logic [TEXT_LEN:0]   end_at;  // length equals this place and the text ends there
  logic  long_text, ended;

  assign seg_chars[0] = c_hi_i;
  assign seg_chars[1] = c_lo_i;
  assign seg_chars[2] = d_hi_i;
  assign seg_chars[3] = d_lo_i;

  // a toggled a/b flag starts a new message
  assign wipe_stage = ctl_i.wipe || (ctl_i.is_rt && (ab_i != ab_q));

  always_comb begin
    for (int i = 0; i < TEXT_LEN; i++) begin
      upd[i] = wipe_stage ? '0 : stage_q[i];
      if (ctl_i.is_rt && (seg_i == 4'(i / RT_SEG_CHARS))) begin
        upd[i] = seg_chars[i % RT_SEG_CHARS];
      end
      nz[i]    = |upd[i];
      blank[i] = nz[i] && (upd[i] <= CHAR_SPACE);
      crlf[i]  = (upd[i] == CHAR_CR) || (upd[i] == CHAR_LF);
    end
  end

  assign pre[0] = 1'b1;
  for (genvar p = 1; p <= TEXT_LEN; p++) begin : g_pre
    assign pre[p] = &nz[p-1:0];
  end

  // texts shorter than two chars never end early
  assign end_at[1:0] = 2'b00;

  // end of text: cr or lf among the trailing chars, or two trailing blanks
  for (genvar p = 2; p <= TEXT_LEN; p++) begin : g_end
    logic len_here;
    if (p < TEXT_LEN) begin : g_mid
      assign len_here = pre[p] && !nz[p];
    end else begin : g_full
      assign len_here = pre[p];
    end
    if (p == 2) begin : g_two
      assign end_at[p] = len_here && crlf[p-1];
    end else if (p == 3) begin : g_three
      assign end_at[p] = len_here && (crlf[p-1] || (blank[p-1] && crlf[p-2]));
    end else begin : g_more
      assign end_at[p] = len_here &&
                         (crlf[p-1] || (blank[p-1] && (crlf[p-2] || blank[p-2])));
    end
  end

  assign ended     = |end_at;
  assign long_text = (seg_i == TEXT_END_SEG) && pre[TEXT_MIN_LONG+1];
  assign done_o    = ctl_i.fire && ctl_i.is_rt && (long_text || ended);

  always_comb begin
    ab_d = (ctl_i.fire && ctl_i.is_rt) ? ab_i : ab_q;
    for (int i = 0; i < TEXT_LEN; i++) begin
      stage_d[i] = stage_q[i];
      pub_d[i]   = pub_q[i];
      if (ctl_i.fire) begin
        stage_d[i] = done_o ? '0 : upd[i];
        if (done_o) begin
          pub_d[i] = upd[i];
        end else if (ctl_i.wipe) begin
          pub_d[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_q <= 1'b0;
      for (int i = 0; i < TEXT_LEN; i++) begin
        stage_q[i] <= '0;
        pub_q[i]   <= '0;
      end
    end else begin
      ab_q <= ab_d;
      for (int i = 0; i < TEXT_LEN; i++) begin
        stage_q[i] <= stage_d[i];
        pub_q[i]   <= pub_d[i];
      end
    end
  end

  for (genvar k = 0; k < TEXT_CHUNKS; k++) begin : g_chunk
    for (genvar j = 0; j < CHUNK_CHARS; j++) begin : g_char
      assign text_chunks_o[k][CHUNK_W-1-j*CHAR_W -: CHAR_W] = pub_q[k*CHUNK_CHARS+j];
    end
  end

endmodule

// ----- design/rta_chunk_emitter.sv -----
// steps through the nine chunks of a published bundle
module rta_chunk_emitter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rta_pkg::emit_ctl_t emit_ctl_i,
  input  logic [15:0]        pi_i,
  input  logic [4:0]         pty_i,
  input  rta_pkg::freq_t     freq_i,
  input  rta_pkg::chunk_t    name_chunk_i,
  input  rta_pkg::chunk_t    text_chunks_i [rta_pkg::TEXT_CHUNKS],
  output rta_pkg::emit_st_t  emit_st_o,
  rta_chunk_if.source        chunk_o
);
  import rta_pkg::*;

  logic       busy_q, busy_d;
  chunk_idx_t idx_q, idx_d;
  done_kind_e kind_q, kind_d;
  logic [2:0] text_idx;
  logic       take;

  assign take     = busy_q && chunk_o.ready;
  assign text_idx = 3'(idx_q - 4'd1);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    kind_d = kind_q;
    if (emit_ctl_i.launch) begin
      busy_d = 1'b1;
      idx_d  = FIRST_CHUNK;
      kind_d = emit_ctl_i.kind;
    end else if (take) begin
      if (idx_q == LAST_CHUNK) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= FIRST_CHUNK;
      kind_q <= DONE_NAME;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      kind_q <= kind_d;
    end
  end

  assign emit_st_o.busy = busy_q;
  assign emit_st_o.free = !busy_q || (take && (idx_q == LAST_CHUNK));

  assign chunk_o.valid       = busy_q;
  assign chunk_o.prog_id     = pi_i;
  assign chunk_o.prog_type   = pty_i;
  assign chunk_o.done_kind   = kind_q;
  assign chunk_o.chunk_index = idx_q;
  assign chunk_o.chunk_chars = (idx_q == FIRST_CHUNK) ? name_chunk_i
                                                      : text_chunks_i[text_idx];
  assign chunk_o.freq_khz    = freq_i;
  assign chunk_o.last        = (idx_q == LAST_CHUNK);

endmodule

// ----- design/rds_text_assembler.sv -----
// top level: rds service name and radiotext assembler
// flow: a group is registered at acceptance and processed once the emitter is free;
//   the first chunk of a completed bundle shows on the output in the cycle after processing
// throughput: one group per cycle while nothing completes; a completion holds the
//   chunk emitter for nine output items, the next group waits in the input register
// reset: staging and published stores, pi, pty and a/b flag clear to zero,
//   tuned frequency to 87500 khz; no clearing pass, ready right after reset
module rds_text_assembler (
  input  logic           clk_i,
  input  logic           rst_ni,
  rta_group_if.sink      group_i,
  rta_chunk_if.source    chunk_o,
  input  logic           cfg_we_i,
  input  rta_pkg::freq_t cfg_wdata_i
);
  import rta_pkg::*;

  `include "rds_text_assembler_macros.svh"

  // input register: holds one group until the emitter can take a bundle
  logic        s1_valid_q, s1_valid_d;
  logic [15:0] a_q, b_q, c_q, d_q;
  logic        clr_q;
  logic        accept;
  logic        proc_fire;

  // published pi and pty, tuned frequency
  logic [15:0] pi_q, pi_d;
  logic [4:0]  pty_q, pty_d;
  freq_t       freq_q;

  grp_ctl_t    grp_ctl;
  emit_ctl_t   emit_ctl;
  emit_st_t    emit_st;
  logic        name_done, text_done;
  chunk_t      name_chunk;
  chunk_t      text_chunks [TEXT_CHUNKS];

  // a group is worked on once no earlier bundle still needs the published stores
  assign proc_fire     = s1_valid_q && emit_st.free;
  assign group_i.ready = !s1_valid_q || proc_fire;
  assign accept        = group_i.valid && group_i.ready;
  assign s1_valid_d    = accept || (s1_valid_q && !proc_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload needs no reset, it is qualified by the valid flag
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q   <= group_i.block_a;
      b_q   <= group_i.block_b;
      c_q   <= group_i.block_c;
      d_q   <= group_i.block_d;
      clr_q <= group_i.clear_first;
    end
  end

  // group decode: type 0 of either version carries the name, 2a the radiotext
  assign grp_ctl.fire  = proc_fire;
  assign grp_ctl.wipe  = clr_q;
  assign grp_ctl.is_ps = (b_q[15:12] == GRP_TYPE_PS);
  assign grp_ctl.is_rt = (b_q[15:12] == GRP_TYPE_RT) && (b_q[11] == GRP_VER_A);

  // pi and pty follow every type 0 group, clear_first on any other group wipes them
  always_comb begin
    pi_d  = pi_q;
    pty_d = pty_q;
    if (proc_fire) begin
      if (grp_ctl.is_ps) begin
        pi_d  = a_q;
        pty_d = b_q[9:5];
      end else if (clr_q) begin
        pi_d  = '0;
        pty_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_q   <= '0;
      pty_q  <= '0;
      freq_q <= FREQ_RESET;
    end else begin
      pi_q  <= pi_d;
      pty_q <= pty_d;
      if (cfg_we_i) begin
        freq_q <= cfg_wdata_i;
      end
    end
  end

  rta_name_unit u_name (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (grp_ctl),
    .seg_i        (b_q[1:0]),
    .d_hi_i       (d_q[14:8]),
    .d_lo_i       (d_q[6:0]),
    .done_o       (name_done),
    .name_chunk_o (name_chunk)
  );

  rta_text_unit u_text (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (grp_ctl),
    .seg_i         (b_q[3:0]),
    .ab_i          (b_q[4]),
    .c_hi_i        (c_q[14:8]),
    .c_lo_i        (c_q[6:0]),
    .d_hi_i        (d_q[14:8]),
    .d_lo_i        (d_q[6:0]),
    .done_o        (text_done),
    .text_chunks_o (text_chunks)
  );

  // a group completes at most one of name or text
  assign emit_ctl.launch = name_done || text_done;
  assign emit_ctl.kind   = text_done ? DONE_TEXT : DONE_NAME;

  rta_chunk_emitter u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_ctl_i    (emit_ctl),
    .pi_i          (pi_q),
    .pty_i         (pty_q),
    .freq_i        (freq_q),
    .name_chunk_i  (name_chunk),
    .text_chunks_i (text_chunks),
    .emit_st_o     (emit_st),
    .chunk_o       (chunk_o)
  );

  // a group is only worked on when the last chunk of a bundle leaves or none is out
  `RTA_ASSERT_IMP(a_proc_waits, clk_i, rst_ni, proc_fire, (!emit_st.busy || (chunk_o.ready && chunk_o.last)), "group processed while chunks pending")

  // a bundle launch comes only from a processed group
  `RTA_ASSERT_IMP(a_launch_src, clk_i, rst_ni, emit_ctl.launch, proc_fire, "bundle launched without a group")

  // a launch shows chunk zero next
  `RTA_ASSERT_NXT(a_launch_first, clk_i, rst_ni, emit_ctl.launch, (chunk_o.valid && (chunk_o.chunk_index == FIRST_CHUNK)), "bundle does not start at chunk zero")

  // chunks of a bundle leave in order without gaps
  `RTA_ASSERT_NXT(a_chunk_step, clk_i, rst_ni, (chunk_o.valid && chunk_o.ready && !chunk_o.last && !emit_ctl.launch), (chunk_o.valid && (chunk_o.chunk_index == ($past(chunk_o.chunk_index) + 4'd1))), "chunk index skipped")

endmodule

// ----- tb/rta_chunk_checker.sv -----
// checker: predicts published rds chunks from accepted groups and compares them
module rta_chunk_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  rta_group_if           group_i,
  rta_chunk_if           chunk_i,
  input  logic           cfg_we_i,
  input  rta_pkg::freq_t cfg_wdata_i,
  output int             mismatches_o,
  output int             pending_o,
  output int             chunks_o,
  output int             name_bundles_o,
  output int             text_bundles_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rta_pkg::*;

  typedef struct {
    logic [15:0] prog_id;
    logic [4:0]  prog_type;
    done_kind_e  kind;
    chunk_idx_t  index;
    chunk_t      chars;
    freq_t       freq;
    logic        last;
  } chunk_rec_t;

  char_t       name_stage [NAME_LEN];
  char_t       text_stage [TEXT_LEN];
  char_t       name_pub   [NAME_LEN];
  char_t       text_pub   [TEXT_LEN];
  logic [15:0] pi_pub;
  logic [4:0]  pty_pub;
  logic        ab_seen;
  freq_t       tuned_freq;
  chunk_rec_t  expected_chunks [$];

  task automatic wipe_stores();
    name_stage = '{default: '0};
    text_stage = '{default: '0};
    name_pub   = '{default: '0};
    text_pub   = '{default: '0};
    pi_pub     = '0;
    pty_pub    = '0;
  endtask

  function automatic int staged_text_len();
    int n;
    n = 0;
    while (n < TEXT_LEN && text_stage[n] != '0) n++;
    return n;
  endfunction

  // scan back from the last char: cr/lf, or blanks running into the third char from the end
  function automatic bit text_terminated(input int len);
    for (int i = len - 1; i > 0; i--) begin
      if (text_stage[i] == CHAR_CR || text_stage[i] == CHAR_LF) return 1'b1;
      if (i <= len - 3) return 1'b1;
      if (text_stage[i] > CHAR_SPACE) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic chunk_t published_chunk(input int k);
    chunk_t v;
    char_t  ch;
    v = '0;
    for (int i = 0; i < CHUNK_CHARS; i++) begin
      ch = (k == 0) ? name_pub[i] : text_pub[(k - 1) * CHUNK_CHARS + i];
      v  = (v << CHAR_W) | chunk_t'(ch);
    end
    return v;
  endfunction

  task automatic queue_bundle(input done_kind_e kind);
    chunk_rec_t rec;
    for (int k = 0; k < NUM_CHUNKS; k++) begin
      rec.prog_id   = pi_pub;
      rec.prog_type = pty_pub;
      rec.kind      = kind;
      rec.index     = chunk_idx_t'(k);
      rec.chars     = published_chunk(k);
      rec.freq      = tuned_freq;
      rec.last      = (k == NUM_CHUNKS - 1);
      expected_chunks.push_back(rec);
    end
    if (kind == DONE_NAME) name_bundles_o++;
    else text_bundles_o++;
  endtask

  task automatic predict_group(input logic [15:0] a, b, c, d, input logic clr);
    int seg;
    int len;
    bit full;
    if (clr) wipe_stores();
    if (b[15:12] == GRP_TYPE_PS) begin
      seg     = int'(b[1:0]);
      pty_pub = b[9:5];
      pi_pub  = a;
      name_stage[seg * PS_SEG_CHARS]     = d[14:8];
      name_stage[seg * PS_SEG_CHARS + 1] = d[6:0];
      full = 1'b1;
      foreach (name_stage[i]) if (name_stage[i] == '0) full = 1'b0;
      if (full) begin
        name_pub   = name_stage;
        name_stage = '{default: '0};
        queue_bundle(DONE_NAME);
      end
    end else if (b[15:12] == GRP_TYPE_RT && b[11] == GRP_VER_A) begin
      seg = int'(b[3:0]);
      if (b[4] != ab_seen) begin
        text_stage = '{default: '0};
        ab_seen    = b[4];
      end
      text_stage[seg * RT_SEG_CHARS]     = c[14:8];
      text_stage[seg * RT_SEG_CHARS + 1] = c[6:0];
      text_stage[seg * RT_SEG_CHARS + 2] = d[14:8];
      text_stage[seg * RT_SEG_CHARS + 3] = d[6:0];
      len = staged_text_len();
      if ((seg == TEXT_END_SEG && len > TEXT_MIN_LONG) || text_terminated(len)) begin
        text_pub   = text_stage;
        text_stage = '{default: '0};
        queue_bundle(DONE_TEXT);
      end
    end
  endtask

  task automatic check_chunk();
    chunk_rec_t want;
    chunks_o++;
    if (expected_chunks.size() == 0) begin
      if (mismatches_o < 10)
        $display("%0t: chunk %0d (kind %0d) arrived with nothing expected",
                 $realtime, chunk_i.chunk_index, chunk_i.done_kind);
      mismatches_o++;
    end else begin
      want = expected_chunks.pop_front();
      if (chunk_i.prog_id !== want.prog_id || chunk_i.prog_type !== want.prog_type ||
          chunk_i.done_kind !== want.kind || chunk_i.chunk_index !== want.index ||
          chunk_i.chunk_chars !== want.chars || chunk_i.freq_khz !== want.freq ||
          chunk_i.last !== want.last) begin
        if (mismatches_o < 10) begin
          $display("%0t: chunk mismatch", $realtime);
          $display("  want pi %h pty %0d kind %0d idx %0d chars %h freq %0d last %0d",
                   want.prog_id, want.prog_type, want.kind, want.index, want.chars,
                   want.freq, want.last);
          $display("  got  pi %h pty %0d kind %0d idx %0d chars %h freq %0d last %0d",
                   chunk_i.prog_id, chunk_i.prog_type, chunk_i.done_kind,
                   chunk_i.chunk_index, chunk_i.chunk_chars, chunk_i.freq_khz, chunk_i.last);
        end
        mismatches_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_stores();
      ab_seen    = 1'b0;
      tuned_freq = FREQ_RESET;
      expected_chunks.delete();
      pending_o <= 0;
    end else begin
      if (chunk_i.valid && chunk_i.ready) check_chunk();
      if (cfg_we_i) tuned_freq = cfg_wdata_i;
      if (group_i.valid && group_i.ready)
        predict_group(group_i.block_a, group_i.block_b, group_i.block_c, group_i.block_d,
                      group_i.clear_first);
      pending_o <= expected_chunks.size();
    end
  end

endmodule

// ----- tb/rds_text_assembler_test.sv -----
// testbench top: drives rds groups, frequency writes and chunk backpressure, gives the verdict
module rds_text_assembler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rta_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int RANDOM_ITEMS  = 220;
  localparam int PHASES        = 5;
  localparam int SETTLE_CYCLES = 6;
  // extended-other-networks group, not decoded by the block
  localparam logic [3:0] GRP_TYPE_EON = 4'd14;

  // how a random radiotext message is terminated
  typedef enum int {END_NONE, END_CR, END_LF, END_BLANKS} text_end_e;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i;
  freq_t cfg_wdata_i;

  int    cycle_count   = 0;
  int    groups_sent   = 0;   // groups the block acts on, ignored types not counted
  int    settings_used = 1;   // the reset frequency counts as the first
  bit    calm          = 1'b0;
  logic  rt_ab         = 1'b0;

  int    mismatches;
  int    pending;
  int    chunks_seen;
  int    name_bundles;
  int    text_bundles;

  rta_group_if group_ch ();
  rta_chunk_if chunk_ch ();

  rds_text_assembler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .group_i     (group_ch),
    .chunk_o     (chunk_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  rta_chunk_checker chunk_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .group_i        (group_ch),
    .chunk_i        (chunk_ch),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .chunks_o       (chunks_seen),
    .name_bundles_o (name_bundles),
    .text_bundles_o (text_bundles)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d chunks still expected", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // chunk receiver: bursts of stall, stretches of ready, no stall in the calm phase
  initial begin
    chunk_ch.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        chunk_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        chunk_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // two 7-bit chars in one block, the unused top bits of each byte random
  function automatic logic [15:0] char_pair(input char_t hi, input char_t lo);
    logic [15:0] w;
    w     = {1'b0, hi, 1'b0, lo};
    w[15] = 1'($urandom_range(0, 1));
    w[7]  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // block b of a service-name group, bits the block ignores are random
  function automatic logic [15:0] ps_block_b(input logic ver, input logic [4:0] pty,
                                             input logic [1:0] seg);
    logic [15:0] b;
    b        = 16'($urandom);
    b[15:12] = GRP_TYPE_PS;
    b[11]    = ver;
    b[9:5]   = pty;
    b[1:0]   = seg;
    return b;
  endfunction

  // block b of a 2a radiotext group, pty bits random
  function automatic logic [15:0] rt_block_b(input logic ab, input logic [3:0] seg);
    logic [15:0] b;
    b        = 16'($urandom);
    b[15:12] = GRP_TYPE_RT;
    b[11]    = GRP_VER_A;
    b[4]     = ab;
    b[3:0]   = seg;
    return b;
  endfunction

  // occasional retune wipe
  function automatic logic clear_rare();
    return ($urandom_range(0, 15) == 0);
  endfunction

  // one item on the group channel, now and then with a random gap ahead of it outside the calm phase
  task automatic send_group(input logic [15:0] a, b, c, d, input logic clr);
    if (!calm && $urandom_range(0, 4) == 0) begin
      group_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    group_ch.valid       <= 1'b1;
    group_ch.block_a     <= a;
    group_ch.block_b     <= b;
    group_ch.block_c     <= c;
    group_ch.block_d     <= d;
    group_ch.clear_first <= clr;
    @(posedge clk_i);
    while (!group_ch.ready) @(posedge clk_i);
    if (b[15:12] == GRP_TYPE_PS || (b[15:12] == GRP_TYPE_RT && b[11] == GRP_VER_A))
      groups_sent++;
  endtask

  // four name segments from one station, starting at a random segment
  task automatic name_run();
    logic [15:0] pi;
    logic [4:0]  pty;
    int          first;
    char_t       hi;
    char_t       lo;
    pi    = 16'($urandom);
    pty   = 5'($urandom);
    first = $urandom_range(0, 3);
    for (int n = 0; n < NAME_LEN / PS_SEG_CHARS; n++) begin
      hi = 7'($urandom_range(1, 127));
      lo = 7'($urandom_range(1, 127));
      // now and then a hole that keeps the name from completing
      if ($urandom_range(0, 11) == 0) lo = '0;
      send_group(pi, ps_block_b(1'($urandom_range(0, 1)), pty, 2'((first + n) % 4)),
                 16'($urandom), char_pair(hi, lo), clear_rare());
    end
  endtask

  // a radiotext message sent in segment order, mostly short, sometimes all sixteen
  task automatic text_run();
    char_t     txt [TEXT_LEN];
    int        nseg;
    int        p;
    int        k;
    text_end_e ending;
    if ($urandom_range(0, 2) == 0) rt_ab = ~rt_ab;
    nseg = ($urandom_range(0, 5) == 0) ? TEXT_LEN / RT_SEG_CHARS : $urandom_range(1, 5);
    foreach (txt[i]) txt[i] = 7'($urandom_range(8'h21, 8'h7e));
    p      = nseg * RT_SEG_CHARS - 1;
    ending = text_end_e'($urandom_range(0, 3));
    case (ending)
      END_CR, END_LF: begin
        // terminator within the last three chars, only blanks after it
        k = $urandom_range(0, 2);
        for (int j = p - k + 1; j <= p; j++) txt[j] = 7'($urandom_range(1, 8'h20));
        txt[p - k] = (ending == END_CR) ? CHAR_CR : CHAR_LF;
      end
      END_BLANKS: begin
        txt[p]     = 7'($urandom_range(1, 8'h20));
        txt[p - 1] = 7'($urandom_range(1, 8'h20));
      end
      default: ;
    endcase
    // rare stray char anywhere, zero included
    if ($urandom_range(0, 9) == 0) txt[$urandom_range(0, p)] = 7'($urandom_range(0, 127));
    for (int s = 0; s < nseg; s++)
      send_group(16'($urandom), rt_block_b(rt_ab, 4'(s)),
                 char_pair(txt[s * 4], txt[s * 4 + 1]),
                 char_pair(txt[s * 4 + 2], txt[s * 4 + 3]), clear_rare());
  endtask

  // unstructured group, half of them steered onto a decoded type
  task automatic noise_group();
    logic [15:0] b;
    b = 16'($urandom);
    case ($urandom_range(0, 3))
      0: b[15:12] = GRP_TYPE_PS;
      1: begin
        b[15:12] = GRP_TYPE_RT;
        b[11]    = GRP_VER_A;
      end
      default: ;
    endcase
    send_group(16'($urandom), b, 16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // hold the sender until every predicted chunk is out, then let the input register settle
  task automatic drain();
    group_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_freq(input freq_t f);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    freq_t       phase_freq [PHASES];
    int          target;
    int          pick;
    logic [15:0] b;

    group_ch.valid       <= 1'b0;
    group_ch.block_a     <= '0;
    group_ch.block_b     <= '0;
    group_ch.block_c     <= '0;
    group_ch.block_d     <= '0;
    group_ch.clear_first <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= FREQ_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs at the reset frequency
    // name of extreme chars, the first group also wipes everything
    send_group(16'hffff, ps_block_b(1'b0, 5'd31, 2'd0), 16'h0000,
               char_pair(7'h7f, 7'h01), 1'b1);
    send_group(16'hffff, ps_block_b(1'b0, 5'd31, 2'd1), 16'hffff,
               char_pair(7'h01, 7'h7f), 1'b0);
    send_group(16'hffff, ps_block_b(1'b1, 5'd31, 2'd2), 16'h0000,
               char_pair(7'h41, 7'h42), 1'b0);
    send_group(16'hffff, ps_block_b(1'b1, 5'd31, 2'd3), 16'hffff,
               char_pair(7'h7f, 7'h7f), 1'b0);
    // zero chars never complete a name, pi and pty still publish
    send_group(16'h0000, ps_block_b(1'b0, 5'd0, 2'd0), 16'h0000, 16'h0000, 1'b1);
    // version b radiotext and an unrelated group type do nothing
    b     = rt_block_b(1'b1, 4'd0);
    b[11] = ~GRP_VER_A;
    send_group(16'($urandom), b, 16'($urandom), 16'($urandom), 1'b0);
    b        = 16'($urandom);
    b[15:12] = GRP_TYPE_EON;
    send_group(16'($urandom), b, 16'($urandom), 16'($urandom), 1'b0);
    // a/b flips to one, carriage return followed by a blank ends the text
    send_group(16'($urandom), rt_block_b(1'b1, 4'd0), char_pair(7'h48, 7'h49),
               char_pair(CHAR_CR, CHAR_SPACE), 1'b0);
    // line feed as the last char
    send_group(16'($urandom), rt_block_b(1'b1, 4'd0), char_pair(7'h41, 7'h42),
               char_pair(7'h43, CHAR_LF), 1'b0);
    // a/b flips back, two trailing blanks at both ends of the blank range
    send_group(16'($urandom), rt_block_b(1'b0, 4'd0), char_pair(7'h41, 7'h42),
               char_pair(CHAR_SPACE, 7'h01), 1'b0);
    // all sixteen segments, full-length text completes on segment fifteen
    for (int s = 0; s < TEXT_LEN / RT_SEG_CHARS; s++)
      send_group(16'($urandom), rt_block_b(1'b0, 4'(s)), char_pair(7'h7f, 7'h21),
                 char_pair(7'h7f, 7'h21), 1'b0);
    rt_ab = 1'b0;

    // random part over several tuning settings, band edges and out-of-band values
    phase_freq[0] = 17'd108000;
    phase_freq[1] = 17'd76000;
    phase_freq[2] = 17'h1ffff;
    phase_freq[3] = 17'h00000;
    phase_freq[4] = freq_t'($urandom_range(76000, 108000));
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_freq(phase_freq[ph]);
      // the last phase runs without idling on either side
      calm   = (ph == PHASES - 1);
      target = groups_sent + RANDOM_ITEMS / PHASES;
      while (groups_sent < target) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) name_run();
        else if (pick < 7) text_run();
        else noise_group();
      end
    end
    drain();

    $display("sent %0d decoded groups over %0d frequency settings", groups_sent,
             settings_used);
    $display("checked %0d chunks from %0d name and %0d radiotext bundles", chunks_seen,
             name_bundles, text_bundles);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
